/* rtl/core/in_order_reorder_buffer_core_macros.svh */
// Assertion macros for the in-order reorder buffer core.
// Included by files that carry concurrent checks; needs clk and rst in scope.
`ifndef IN_ORDER_REORDER_BUFFER_CORE_MACROS_SVH
`define IN_ORDER_REORDER_BUFFER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IORB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define IORB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IORB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IORB_ASSERT_ALWAYS(label, cond, msg)
`define IORB_ASSERT_IMPLY(label, ante, cons, msg)
`define IORB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/core/iorb_pkg.sv */
// Shared types and codes for the in-order reorder buffer core.
// No dependencies; used by every module of the block.
package iorb_pkg;

  localparam int unsigned WINDOW_DEF     = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned OFF_W     = 32;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned STATUS_W  = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ACK_W     = 2;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QP_W    = $clog2(Q_DEPTH);
  localparam int unsigned QC_W    = $clog2(Q_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_ITEM   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STATUS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;

  localparam logic [ACK_W-1:0] ACK_MORE     = 2'd0;
  localparam logic [ACK_W-1:0] ACK_DONE     = 2'd1;
  localparam logic [ACK_W-1:0] ACK_OVERFLOW = 2'd2;
  localparam logic [ACK_W-1:0] ACK_STALE    = 2'd3;

  typedef enum logic [1:0] {
    OP_ACK,
    OP_STORE,
    OP_DEFER,
    OP_CLOSE
  } op_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    op_t                  op;
    logic [ACK_W-1:0]     ack;
    logic                 set_end;
    logic [OFF_W-1:0]     offset;
    logic [PAYLOAD_W-1:0] payload;
    logic [STATUS_W-1:0]  status;
  } cmd_t;

  // Architectural state seen by the front when it classifies
  typedef struct packed {
    logic [OFF_W-1:0] nte;
    logic [OFF_W-1:0] end_offset;
    logic             closed;
    logic             idle;
    logic             clearing;
  } status_t;

endpackage

/* rtl/core/iorb_front.sv */
// Front end: input register and classifier of the reorder buffer core.
// Depends on iorb_pkg; reads the back end's status, pushes into iorb_queue.
module iorb_front #(
  parameter int unsigned WINDOW = iorb_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [iorb_pkg::MODE_W-1:0]    mode,
  input  logic [iorb_pkg::OFF_W-1:0]     seq_offset,
  input  logic [iorb_pkg::PAYLOAD_W-1:0] payload,
  input  logic [iorb_pkg::STATUS_W-1:0]  status_code,
  input  iorb_pkg::status_t              st,
  input  logic                           q_empty,
  output logic                           q_push,
  output iorb_pkg::cmd_t                 q_cmd
);
  import iorb_pkg::*;

  logic                 held;
  logic [MODE_W-1:0]    item_mode;
  logic [OFF_W-1:0]     item_off;
  logic [PAYLOAD_W-1:0] item_payload;
  logic [STATUS_W-1:0]  item_status;
  logic [OFF_W-1:0]     diff;
  logic                 past_end;
  logic                 stale;
  logic                 in_window;

  assign in_ready = !held && !st.clearing;
  // classify only against settled state: back idle and nothing queued
  assign q_push   = held && st.idle && q_empty;

  assign diff      = item_off - st.nte;
  assign past_end  = st.closed || (item_off >= st.end_offset);
  assign stale     = item_off < st.nte;
  assign in_window = diff < OFF_W'(WINDOW);

  always_comb begin
    q_cmd         = '0;
    q_cmd.op      = OP_ACK;
    q_cmd.ack     = ACK_DONE;
    q_cmd.offset  = item_off;
    q_cmd.payload = item_payload;
    q_cmd.status  = item_status;
    case (item_mode)
      MODE_ITEM: begin
        if (past_end) begin
          q_cmd.ack = ACK_DONE;
        end else if (stale) begin
          q_cmd.ack = ACK_STALE;
        end else if (!in_window) begin
          q_cmd.ack = ACK_OVERFLOW;
        end else begin
          q_cmd.op = OP_STORE;
        end
      end
      MODE_STATUS: begin
        if (past_end) begin
          q_cmd.ack = ACK_DONE;
        end else if (stale) begin
          q_cmd.ack = ACK_STALE;
        end else if (item_off == st.nte) begin
          q_cmd.op      = OP_CLOSE;
          q_cmd.set_end = 1'b1;
        end else begin
          q_cmd.op = OP_DEFER;
        end
      end
      MODE_CANCEL: begin
        if (!st.closed) begin
          q_cmd.op = OP_CLOSE;
        end
      end
      default: begin
        q_cmd.ack = ACK_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_mode    <= mode;
      item_off     <= seq_offset;
      item_payload <= payload;
      item_status  <= status_code;
    end
  end

endmodule

/* rtl/core/iorb_queue.sv */
// Short command queue between the front and back ends.
// Depends on iorb_pkg for the command word and depth.
module iorb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  iorb_pkg::cmd_t push_cmd,
  input  logic           pop,
  output iorb_pkg::cmd_t pop_cmd,
  output logic           empty,
  output logic           full
);
  import iorb_pkg::*;

  cmd_t            entries [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QC_W'(Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/core/iorb_back.sv */
// Back end: slot memory, in-order drain sequencer and output register.
// Depends on iorb_pkg; pops commands from iorb_queue.
module iorb_back #(
  parameter int unsigned WINDOW     = iorb_pkg::WINDOW_DEF,
  parameter int unsigned DATA_WIDTH = iorb_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  iorb_pkg::cmd_t                 q_cmd,
  output logic                           q_pop,
  output iorb_pkg::status_t              st,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [iorb_pkg::KIND_W-1:0]    out_kind,
  output logic [iorb_pkg::PAYLOAD_W-1:0] out_data,
  output logic [iorb_pkg::STATUS_W-1:0]  out_status,
  output logic [iorb_pkg::ACK_W-1:0]     ack_code,
  output logic                           last
);
  import iorb_pkg::*;

  localparam int unsigned IW = $clog2(WINDOW);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_CLOSE = 7'b0100000,
    S_ACK   = 7'b1000000
  } state_t;

  state_t              state, state_next;
  logic [OFF_W-1:0]    nte, nte_next;
  logic [OFF_W-1:0]    end_offset, end_offset_next;
  logic [STATUS_W-1:0] pending_status, pending_status_next;
  logic                closed, closed_next;
  logic [IW-1:0]       head, head_next;
  logic [IW-1:0]       clr_addr, clr_addr_next;
  logic [STATUS_W-1:0] shut_status, shut_status_next;
  logic [ACK_W-1:0]    ack_pend, ack_pend_next;

  logic [OFF_W-1:0]      cur_off;
  logic [DATA_WIDTH-1:0] cur_data;
  logic                  load_cur;

  // slot memory: tag holds the offset stored there, all ones when cleared
  logic [OFF_W-1:0]      mem_tag  [WINDOW];
  logic [DATA_WIDTH-1:0] mem_data [WINDOW];
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [OFF_W-1:0]      mem_wtag;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [OFF_W-1:0]      rd_tag;
  logic [DATA_WIDTH-1:0] rd_data;

  logic [OFF_W-1:0] diff;
  logic [IW:0]      slot_sum;
  logic [IW-1:0]    slot;

  logic                 out_free;
  logic                 out_load;
  logic [KIND_W-1:0]    o_kind;
  logic [PAYLOAD_W-1:0] o_data;
  logic [STATUS_W-1:0]  o_status;
  logic [ACK_W-1:0]     o_ack;
  logic                 o_last;

  assign out_free = !out_valid || out_ready;

  assign diff     = cur_off - nte;
  assign slot_sum = {1'b0, head} + {1'b0, diff[IW-1:0]};
  assign slot     = (slot_sum >= (IW+1)'(WINDOW)) ?
                    IW'(slot_sum - (IW+1)'(WINDOW)) : slot_sum[IW-1:0];

  assign st.nte        = nte;
  assign st.end_offset = end_offset;
  assign st.closed     = closed;
  assign st.idle       = (state == S_IDLE);
  assign st.clearing   = (state == S_CLEAR);

  always_comb begin
    state_next          = state;
    nte_next            = nte;
    end_offset_next     = end_offset;
    pending_status_next = pending_status;
    closed_next         = closed;
    head_next           = head;
    clr_addr_next       = clr_addr;
    shut_status_next    = shut_status;
    ack_pend_next       = ack_pend;
    q_pop               = 1'b0;
    load_cur            = 1'b0;
    mem_we              = 1'b0;
    mem_waddr           = clr_addr;
    mem_wtag            = '1;
    mem_wdata           = '0;
    out_load            = 1'b0;
    o_kind              = KIND_ACK;
    o_data              = '0;
    o_status            = '0;
    o_ack               = '0;
    o_last              = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == IW'(WINDOW - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          load_cur = 1'b1;
          case (q_cmd.op)
            OP_STORE: begin
              state_next = S_WRITE;
            end
            OP_DEFER: begin
              end_offset_next     = q_cmd.offset;
              pending_status_next = q_cmd.status;
              ack_pend_next       = ACK_MORE;
              state_next          = S_ACK;
            end
            OP_CLOSE: begin
              if (q_cmd.set_end) begin
                end_offset_next = q_cmd.offset;
              end
              shut_status_next = q_cmd.status;
              ack_pend_next    = ACK_DONE;
              state_next       = S_CLOSE;
            end
            default: begin
              ack_pend_next = q_cmd.ack;
              state_next    = S_ACK;
            end
          endcase
        end
      end
      S_WRITE: begin
        mem_we     = 1'b1;
        mem_waddr  = slot;
        mem_wtag   = cur_off;
        mem_wdata  = cur_data;
        state_next = S_READ;
      end
      S_READ: begin
        // wait for the head slot to come out of the memory
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if ((nte != end_offset) && (rd_tag == nte)) begin
          if (out_free) begin
            out_load   = 1'b1;
            o_kind     = KIND_DATA;
            o_data     = PAYLOAD_W'(rd_data);
            nte_next   = nte + 1'b1;
            head_next  = (head == IW'(WINDOW - 1)) ? '0 : head + 1'b1;
            state_next = S_READ;
          end
        end else if (nte == end_offset) begin
          shut_status_next = pending_status;
          ack_pend_next    = ACK_DONE;
          state_next       = S_CLOSE;
        end else begin
          ack_pend_next = ACK_MORE;
          state_next    = S_ACK;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_load    = 1'b1;
          o_kind      = KIND_CLOSE;
          o_status    = shut_status;
          closed_next = 1'b1;
          state_next  = S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_kind     = KIND_ACK;
          o_ack      = ack_pend;
          o_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      nte            <= '0;
      end_offset     <= '1;
      pending_status <= '0;
      closed         <= 1'b0;
      head           <= '0;
      clr_addr       <= '0;
      shut_status    <= '0;
      ack_pend       <= ACK_DONE;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      nte            <= nte_next;
      end_offset     <= end_offset_next;
      pending_status <= pending_status_next;
      closed         <= closed_next;
      head           <= head_next;
      clr_addr       <= clr_addr_next;
      shut_status    <= shut_status_next;
      ack_pend       <= ack_pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_off  <= q_cmd.offset;
      cur_data <= DATA_WIDTH'(q_cmd.payload);
    end
    if (out_load) begin
      out_kind   <= o_kind;
      out_data   <= o_data;
      out_status <= o_status;
      ack_code   <= o_ack;
      last       <= o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_tag[mem_waddr]  <= mem_wtag;
      mem_data[mem_waddr] <= mem_wdata;
    end
    rd_tag  <= mem_tag[head];
    rd_data <= mem_data[head];
  end

endmodule

/* rtl/core/in_order_reorder_buffer_core.sv */
// Channel | dir | handshake            | word
// --------+-----+----------------------+--------------------------------------------
// in      | in  | in_valid / in_ready  | mode, seq_offset, payload, status_code
// out     | out | out_valid / out_ready| out_kind, out_data, out_status, ack_code, last
//
// One input word at a time. An ack-only word goes to the ack state; a closing
// one goes through close first. A stored payload is written, then each released
// word is read via the slot memory's single read port and checked, then close if
// due and ack. After reset a clearing pass marks every slot empty; in_ready stays
// low meanwhile. The output register lets in take the next word while a result
// waits; a stalled out holds the back end and then the front.
`include "in_order_reorder_buffer_core_macros.svh"
module in_order_reorder_buffer_core #(
  parameter int unsigned WINDOW     = iorb_pkg::WINDOW_DEF,
  parameter int unsigned DATA_WIDTH = iorb_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [iorb_pkg::MODE_W-1:0]    mode,
  input  logic [iorb_pkg::OFF_W-1:0]     seq_offset,
  input  logic [iorb_pkg::PAYLOAD_W-1:0] payload,
  input  logic [iorb_pkg::STATUS_W-1:0]  status_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [iorb_pkg::KIND_W-1:0]    out_kind,
  output logic [iorb_pkg::PAYLOAD_W-1:0] out_data,
  output logic [iorb_pkg::STATUS_W-1:0]  out_status,
  output logic [iorb_pkg::ACK_W-1:0]     ack_code,
  output logic                           last
);
  import iorb_pkg::*;

  status_t st;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    q_push;
  logic    q_pop;
  logic    q_empty;
  logic    q_full;

  iorb_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .seq_offset  (seq_offset),
    .payload     (payload),
    .status_code (status_code),
    .st          (st),
    .q_empty     (q_empty),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  iorb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  iorb_back #(
    .WINDOW     (WINDOW),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .st         (st),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .out_status (out_status),
    .ack_code   (ack_code),
    .last       (last)
  );

  `IORB_ASSERT_ALWAYS(a_nte_within_end, st.nte <= st.end_offset, "release passed end offset")
  `IORB_ASSERT_NEXT(a_closed_sticky, st.closed, st.closed, "stream reopened after close")
  `IORB_ASSERT_IMPLY(a_last_is_ack, out_valid && last, out_kind == KIND_ACK, "last on non-ack word")
  `IORB_ASSERT_IMPLY(a_queue_room, q_push, !q_full, "command pushed into full queue")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for in_order_reorder_buffer_core: offset-tagged words with random gaps and
// back-pressure, each output word checked against a scoreboard that predicts the release order.
// Depends on iorb_pkg and the core RTL only.
module tb_top;
  import iorb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;
  localparam logic [OFF_W-1:0]  OFF_TOP       = '1;
  localparam int unsigned       WIN           = WINDOW_DEF;
  localparam int                RANDOM_WORDS  = 380;
  localparam int                HOLD_AT       = 300;
  localparam int                HOLD_CYCLES   = 300;
  localparam int                SETTLE_CYCLES = 40;
  localparam int                MAX_SHOWN     = 10;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [PAYLOAD_W-1:0] data;
    logic [STATUS_W-1:0]  status;
    logic [ACK_W-1:0]     ack;
    logic                 lst;
  } out_word_t;

  class release_scoreboard;
    logic [OFF_W-1:0]     next_out;
    logic [OFF_W-1:0]     end_off;
    logic [STATUS_W-1:0]  held_status;
    logic [PAYLOAD_W-1:0] slot_data [WIN];
    bit                   slot_full [WIN];
    bit                   is_closed;
    out_word_t            due_q[$];
    int                   mismatches;

    function new();
      next_out    = '0;
      end_off     = '1;
      held_status = '0;
      is_closed   = 1'b0;
      mismatches  = 0;
      foreach (slot_full[i]) slot_full[i] = 1'b0;
    endfunction

    function void queue_result(logic [KIND_W-1:0] kind, logic [PAYLOAD_W-1:0] data,
                               logic [STATUS_W-1:0] status, logic [ACK_W-1:0] ack,
                               logic lst);
      out_word_t w;
      w.kind   = kind;
      w.data   = data;
      w.status = status;
      w.ack    = ack;
      w.lst    = lst;
      due_q.push_back(w);
    endfunction

    // Work out every word that one accepted input word releases
    function void note_word(logic [MODE_W-1:0] m, logic [OFF_W-1:0] off,
                            logic [PAYLOAD_W-1:0] pay, logic [STATUS_W-1:0] st);
      logic [ACK_W-1:0] code;
      code = ACK_DONE;
      if (m == MODE_ITEM) begin
        if (is_closed || off >= end_off) begin
          code = ACK_DONE;
        end else if (off < next_out) begin
          code = ACK_STALE;
        end else if (off - next_out >= WIN) begin
          code = ACK_OVERFLOW;
        end else begin
          slot_data[off % WIN] = pay;
          slot_full[off % WIN] = 1'b1;
          // drain the run of held slots, never past the end point
          while (next_out != end_off && slot_full[next_out % WIN]) begin
            queue_result(KIND_DATA, slot_data[next_out % WIN], '0, ACK_MORE, 1'b0);
            slot_full[next_out % WIN] = 1'b0;
            next_out++;
          end
          if (next_out == end_off) begin
            queue_result(KIND_CLOSE, '0, held_status, ACK_MORE, 1'b0);
            is_closed = 1'b1;
            code = ACK_DONE;
          end else begin
            code = ACK_MORE;
          end
        end
      end else if (m == MODE_STATUS) begin
        if (is_closed || off >= end_off) begin
          code = ACK_DONE;
        end else if (off < next_out) begin
          code = ACK_STALE;
        end else begin
          end_off = off;
          if (off == next_out) begin
            queue_result(KIND_CLOSE, '0, st, ACK_MORE, 1'b0);
            is_closed = 1'b1;
            code = ACK_DONE;
          end else begin
            held_status = st;
            code = ACK_MORE;
          end
        end
      end else if (m == MODE_CANCEL) begin
        if (!is_closed) begin
          queue_result(KIND_CLOSE, '0, st, ACK_MORE, 1'b0);
          is_closed = 1'b1;
        end
        code = ACK_DONE;
      end
      queue_result(KIND_ACK, '0, '0, code, 1'b1);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected output word kind %0d data %h status %h ack %0d last %0b",
                   $time, got.kind, got.data, got.status, got.ack, got.lst);
        return;
      end
      want = due_q[0];
      due_q.delete(0);
      if (got.kind !== want.kind || got.data !== want.data || got.status !== want.status ||
          got.ack !== want.ack || got.lst !== want.lst) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $write("%0t: word mismatch, expected kind %0d data %h status %h ack %0d last %0b,",
                 $time, want.kind, want.data, want.status, want.ack, want.lst);
          $display(" got kind %0d data %h status %h ack %0d last %0b",
                   got.kind, got.data, got.status, got.ack, got.lst);
        end
      end
    endfunction
  endclass

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    mode        = '0;
  logic [OFF_W-1:0]     seq_offset  = '0;
  logic [PAYLOAD_W-1:0] payload     = '0;
  logic [STATUS_W-1:0]  status_code = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [KIND_W-1:0]    out_kind;
  logic [PAYLOAD_W-1:0] out_data;
  logic [STATUS_W-1:0]  out_status;
  logic [ACK_W-1:0]     ack_code;
  logic                 last;

  release_scoreboard sb = new();
  logic [OFF_W-1:0]  batch_q[$];
  int                send_calm = 0;
  int                take_calm = 0;

  always #2 clk = ~clk;

  in_order_reorder_buffer_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .seq_offset  (seq_offset),
    .payload     (payload),
    .status_code (status_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_data    (out_data),
    .out_status  (out_status),
    .ack_code    (ack_code),
    .last        (last)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(mode, seq_offset, payload, status_code);
      if (out_valid && out_ready)
        sb.check_word(out_word_t'{out_kind, out_data, out_status, ack_code, last});
    end
  end

  // Random idle gap before each word, with the odd stretch of back-to-back words
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [PAYLOAD_W-1:0] rand_payload();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void shuffle_batch();
    logic [OFF_W-1:0] t;
    int j;
    for (int i = batch_q.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = batch_q[i];
      batch_q[i] = batch_q[j];
      batch_q[j] = t;
    end
  endfunction

  task automatic offer_word(input logic [MODE_W-1:0] m, input logic [OFF_W-1:0] off,
                            input logic [PAYLOAD_W-1:0] pay, input logic [STATUS_W-1:0] st);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    seq_offset  <= off;
    payload     <= pay;
    status_code <= st;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_item(input logic [OFF_W-1:0] off);
    offer_word(MODE_ITEM, off, rand_payload(), STATUS_W'($urandom));
  endtask

  // Send offsets first .. first+n-1 in shuffled order
  task automatic send_run(input logic [OFF_W-1:0] first, input int n);
    batch_q.delete();
    for (int i = 0; i < n; i++) batch_q.push_back(first + i);
    shuffle_batch();
    foreach (batch_q[i]) send_item(batch_q[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  // Words that must not disturb the in-order stream
  task automatic send_noise(input logic [OFF_W-1:0] stale_top, input logic [OFF_W-1:0] top,
                            input logic [OFF_W-1:0] recent);
    case ($urandom_range(0, 7))
      0:       send_item(stale_top > 0 ? $urandom_range(0, stale_top - 1) : OFF_TOP);
      1:       send_item(top + WIN + $urandom_range(0, 4095));
      2:       send_item($urandom);
      3:       send_item(OFF_TOP);
      4:       offer_word(MODE_UNUSED, $urandom, $urandom, STATUS_W'($urandom));
      5:       offer_word(MODE_STATUS, stale_top > 0 ? $urandom_range(0, stale_top - 1) : OFF_TOP,
                          $urandom, STATUS_W'($urandom));
      6:       offer_word(MODE_STATUS, OFF_TOP, $urandom, STATUS_W'($urandom));
      default: send_item(recent);
    endcase
  endtask

  initial begin
    int taken;
    int hold;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      hold = draw_gap(take_calm);
      // hold off long enough to back the block up into its input
      if (taken == HOLD_AT) hold = HOLD_CYCLES;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    logic [OFF_W-1:0] base;
    logic [OFF_W-1:0] late;
    logic [OFF_W-1:0] lowest;
    logic [OFF_W-1:0] recent;
    bit               late_held;
    bit               carried;
    bit               paused;
    int               sent;
    int               k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    offer_word(MODE_ITEM, 32'd1, '1, '0);
    offer_word(MODE_ITEM, 32'd0, '0, '1);
    offer_word(MODE_ITEM, 32'd0, $urandom, '0);
    offer_word(MODE_ITEM, OFF_TOP, $urandom, '0);
    offer_word(MODE_ITEM, 32'd3, 32'h1111_1111, '0);
    offer_word(MODE_ITEM, 32'd3, 32'h2222_2222, '0);
    offer_word(MODE_ITEM, 32'd2, $urandom, '0);
    offer_word(MODE_ITEM, 32'd4 + WIN, $urandom, '0);
    offer_word(MODE_STATUS, 32'd0, '0, '1);
    offer_word(MODE_STATUS, OFF_TOP, '0, '0);
    offer_word(MODE_UNUSED, $urandom, $urandom, STATUS_W'($urandom));
    offer_word(MODE_ITEM, 32'd4 + WIN - 1, $urandom, '0);
    send_run(32'd5, WIN - 2);
    // fill the head: the whole window goes out at once
    send_item(32'd4);
    wait_drained();

    base      = sb.next_out;
    recent    = base - 1;
    late      = '0;
    late_held = 1'b0;
    paused    = 1'b0;
    sent      = 0;
    while (sent < RANDOM_WORDS || late_held) begin
      if (!paused && !late_held && sent >= RANDOM_WORDS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      k = $urandom_range(1, 8);
      batch_q.delete();
      for (int i = 0; i < k; i++) batch_q.push_back(base + i);
      carried = late_held;
      if (late_held) batch_q.push_back(late);
      late_held = 1'b0;
      shuffle_batch();
      // hold one offset back to the next batch, keeping the span inside the window
      if (!carried && sent + 16 < RANDOM_WORDS && $urandom_range(0, 5) == 0) begin
        late = batch_q.pop_back();
        late_held = 1'b1;
      end
      lowest = base;
      foreach (batch_q[i]) if (batch_q[i] < lowest) lowest = batch_q[i];
      if (late_held && late < lowest) lowest = late;
      foreach (batch_q[i]) begin
        if ($urandom_range(0, 4) == 0) begin
          send_noise(lowest, base + k, recent);
          sent++;
        end
        send_item(batch_q[i]);
        recent = batch_q[i];
        sent++;
      end
      base = base + k;
    end
    wait_drained();

    base = sb.next_out;
    case ($urandom_range(0, 3))
      0: begin
        offer_word(MODE_STATUS, base + WIN, '0, STATUS_W'($urandom));
        send_run(base + 1, WIN - 1);
        send_item(base);
      end
      1: begin
        // slot beyond the new end point stays unreleased
        send_item(base + 12);
        offer_word(MODE_STATUS, base + 6, '0, STATUS_W'($urandom));
        offer_word(MODE_STATUS, base + 9, '0, STATUS_W'($urandom));
        send_item(base + 10);
        send_run(base + 1, 5);
        send_item(base);
      end
      2: begin
        send_item(base + 2);
        offer_word(MODE_STATUS, base, '0, STATUS_W'($urandom));
      end
      default: begin
        send_item(base + 1);
        offer_word(MODE_CANCEL, $urandom, '0, STATUS_W'($urandom));
      end
    endcase
    send_item(base + 1);
    offer_word(MODE_STATUS, base + 1, '0, STATUS_W'($urandom));
    offer_word(MODE_CANCEL, base, '0, STATUS_W'($urandom));
    offer_word(MODE_UNUSED, base, $urandom, STATUS_W'($urandom));
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/iorb_pkg.sv
rtl/core/iorb_front.sv
rtl/core/iorb_queue.sv
rtl/core/iorb_back.sv
rtl/core/in_order_reorder_buffer_core.sv
test/tb_top.sv
